// File: hdl/shabs_pkg.sv
package shabs_pkg;

   // padding layout inside one 64-byte block
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [1:0] LAST_WORD_IDX = 2'd3;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUTPUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         buf_wr;
      byte_src_type src;
      logic         count_en;
      logic         vars_load;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         hash_add;
      logic         hash_init;
      logic [1:0]   word_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_len;
   } dp_status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// File: hdl/shabs_ctrl.sv
module shabs_ctrl
   import shabs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_byte_valid,
   input  logic          req_end_of_message,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_word_index,
   output logic          rsp_last_word,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   ctrl_state_type ret_ff, ret_in;
   logic [5:0]     round_ff, round_in;
   logic [1:0]     word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.word_idx  = word_ff;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_byte_valid) begin
                  cmd.buf_wr   = 1'b1;
                  cmd.src      = SRC_INPUT;
                  cmd.count_en = 1'b1;
                  if (status.fill_last) begin
                     state_in = ST_LOAD;
                     ret_in   = req_end_of_message ? ST_PAD_MARK : ST_IDLE;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD_MARK;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_LOAD: begin
            cmd.vars_load = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.hash_add = 1'b1;
            state_in     = ret_ff;
         end
         ST_PAD_MARK: begin
            cmd.buf_wr = 1'b1;
            cmd.src    = SRC_MARK;
            if (status.fill_last) begin
               state_in = ST_LOAD;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.fill_len) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.buf_wr = 1'b1;
               cmd.src    = SRC_ZERO;
               if (status.fill_last) begin
                  state_in = ST_LOAD;
                  ret_in   = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.buf_wr = 1'b1;
            cmd.src    = SRC_LEN;
            if (status.fill_last) begin
               state_in = ST_LOAD;
               ret_in   = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               word_in = word_ff + 2'd1;
               if (word_ff == LAST_WORD_IDX) begin
                  cmd.hash_init = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = word_ff;
   assign rsp_last_word  = (word_ff == LAST_WORD_IDX);

endmodule

// File: hdl/shabs_datapath.sv
module shabs_datapath
   import shabs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    req_byte_value,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic [63:0]   digest_word
);

   logic [31:0] hash_ff  [8];
   logic [31:0] hash_in  [8];
   logic [31:0] vars_ff  [8];
   logic [31:0] vars_in  [8];
   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;

   logic [7:0]  wr_byte;
   logic [31:0] w_exp, w_cur, t1, t2;

   // byte source for the block buffer
   always_comb begin
      unique case (cmd.src)
         SRC_INPUT: wr_byte = req_byte_value;
         SRC_MARK:  wr_byte = PAD_BYTE;
         SRC_ZERO:  wr_byte = 8'h00;
         SRC_LEN:   wr_byte = count_ff[{~fill_ff[2:0], 3'b000} +: 8];
         default:   wr_byte = 8'h00;
      endcase
   end

   // schedule window: entry 0 is w[t-16], entry 15 is w[t-1] from round 16 on
   assign w_exp = sched_ff[0] + small_sig0(sched_ff[1]) + sched_ff[9]
                  + small_sig1(sched_ff[14]);
   assign w_cur = (cmd.round_idx[5:4] == 2'b00) ? sched_ff[0] : w_exp;

   assign t1 = vars_ff[7] + big_sig1(vars_ff[4])
               + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
               + ROUND_K[cmd.round_idx] + w_cur;
   assign t2 = big_sig0(vars_ff[0])
               + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                  ^ (vars_ff[1] & vars_ff[2]));

   always_comb begin
      sched_in = sched_ff;
      if (cmd.buf_wr) begin
         sched_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = wr_byte;
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[15] = w_cur;
      end
   end

   always_comb begin
      vars_in = vars_ff;
      if (cmd.vars_load) begin
         vars_in = hash_ff;
      end else if (cmd.round_en) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
   end

   always_comb begin
      hash_in  = hash_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (cmd.hash_init) begin
         hash_in  = HASH_INIT;
         fill_in  = '0;
         count_in = '0;
      end else begin
         if (cmd.hash_add) begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
         end
         // fill wraps to zero when a block completes
         if (cmd.buf_wr) begin
            fill_in = fill_ff + 6'd1;
         end
         if (cmd.count_en) begin
            count_in = count_ff + 64'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_INIT;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      vars_ff  <= vars_in;
   end

   assign status.fill_last = (fill_ff == LAST_POS);
   assign status.fill_len  = (fill_ff == LEN_POS);

   assign digest_word = {hash_ff[{cmd.word_idx, 1'b0}], hash_ff[{cmd.word_idx, 1'b1}]};

endmodule

// File: hdl/sha256_byte_stream_hasher_unit.sv
// sha-256 hasher fed one message byte per item
//
// input channel (req_): byte value, byte-valid flag and end-of-message flag.
// an item with byte_valid low and end_of_message low is an idle item and
// changes nothing. end_of_message finalizes the message after the optional
// byte; the block pads, appends the 64-bit bit length and compresses.
// result channel (rsp_): four 64-bit big-endian digest words, index 0 first,
// last_word high on index 3. then the block is back at its initial state.
// timing: a byte item is taken while the block is idle; the 64th byte of a
// block adds a compression (load, 64 rounds at one per cycle in the round
// unit, hash update), during which no byte is taken.
// end of message: padding (marker, zero and length bytes) plus one or two
// compressions, then the four words, one per cycle unless the receiver stalls.
// req_stall is high whenever the block is compressing, padding or holding
// digest words. a stalled digest word holds still until taken.
// reset (synchronous, active high) restores the initial hash values and
// clears the fill position and bit count; no clearing pass is needed.
module sha256_byte_stream_hasher_unit
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   // command and status between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: byte intake, padding steps, round count, digest output
   shabs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .cmd                (cmd),
      .status             (status)
   );

   // datapath: block buffer doubling as schedule window, round unit, hash state
   shabs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_byte_value (req_byte_value),
      .cmd            (cmd),
      .status         (status),
      .digest_word    (rsp_digest_word)
   );

endmodule

// File: hdl/shabs_checker.sv
module shabs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // a stalled digest word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
                                 && $stable(rsp_word_index))
      else $error("stalled digest word changed");

   // no new input taken while digest words are pending
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during digest output");

   // last flag marks exactly the fourth word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last_word does not match word index");

   // words follow in order without gaps
   a_word_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 2'd1))
      else $error("digest word sequence broken");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sha256_byte_stream_hasher_unit shabs_checker u_shabs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);
